// ===== rtl/core/i2c_master_sequencer_defines.svh =====
// Assertion helpers used by the engine RTL
`ifndef I2C_MASTER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SEQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/i2cms_pkg.sv =====
`timescale 1ns / 1ps
package i2cms_pkg;

   localparam int COUNT_WIDTH = 16;

   localparam int REQ_TDATA_WIDTH = 64;
   localparam int RSP_TDATA_WIDTH = 32;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_EVENT = 1'b1
   } action_type;

   typedef enum logic [3:0] {
      BUS_START     = 4'd0,
      BUS_RSTART    = 4'd1,
      BUS_SLAW_ACK  = 4'd2,
      BUS_SLAW_NACK = 4'd3,
      BUS_WR_ACK    = 4'd4,
      BUS_WR_NACK   = 4'd5,
      BUS_ARB_LOST  = 4'd6,
      BUS_SLAR_ACK  = 4'd7,
      BUS_SLAR_NACK = 4'd8,
      BUS_RD_ACK    = 4'd9,
      BUS_RD_NACK   = 4'd10,
      BUS_OTHER     = 4'd11
   } bus_status_type;

   typedef enum logic [1:0] {
      CTL_NONE = 2'd0,
      CTL_SET  = 2'd1,
      CTL_CLR  = 2'd2
   } ctl_type;

   typedef enum logic [1:0] {
      DONE_OK   = 2'd0,
      DONE_ADDR = 2'd1,
      DONE_DATA = 2'd2,
      DONE_ARB  = 2'd3
   } done_type;

   typedef struct packed {
      action_type  action;
      logic [6:0]  target_address;
      logic [15:0] write_count;
      logic [15:0] read_count;
      logic [3:0]  bus_status;
      logic [7:0]  write_byte;
      logic [7:0]  read_byte;
   } req_item_type;

   typedef struct packed {
      logic       request_status;
      logic       data_load;
      logic [7:0] data_out;
      ctl_type    start_ctl;
      ctl_type    ack_ctl;
      logic       stop_set;
      logic       continue_bus;
      logic       write_consumed;
      logic       read_valid;
      logic [7:0] read_data;
      logic       done_res;
      done_type   done_status;
   } rsp_item_type;

endpackage

// ===== rtl/core/i2cms_in_stage.sv =====
`timescale 1ns / 1ps
module i2cms_in_stage
   import i2cms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         held_valid,
   output req_item_type held_item,
   input  logic         held_take
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign in_ready   = !valid_ff || held_take;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

// ===== rtl/core/i2cms_engine.sv =====
`timescale 1ns / 1ps
`include "i2c_master_sequencer_defines.svh"
module i2cms_engine
   import i2cms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   output logic         item_take,
   input  logic         slot_free,
   output logic         rsp_load,
   output rsp_item_type rsp_item
);

   logic [6:0]             slave_addr_ff;
   logic [6:0]             slave_addr_in;
   logic [COUNT_WIDTH-1:0] write_remaining_ff;
   logic [COUNT_WIDTH-1:0] write_remaining_in;
   logic [COUNT_WIDTH-1:0] read_remaining_ff;
   logic [COUNT_WIDTH-1:0] read_remaining_in;
   logic [COUNT_WIDTH-1:0] read_dec;
   logic                   fire;
   rsp_item_type           rsp;

   assign fire      = item_valid && slot_free;
   assign item_take = fire;
   assign rsp_load  = fire;
   assign rsp_item  = rsp;
   assign read_dec  = read_remaining_ff - COUNT_WIDTH'(1);

   always_comb begin
      rsp                = '0;
      slave_addr_in      = slave_addr_ff;
      write_remaining_in = write_remaining_ff;
      read_remaining_in  = read_remaining_ff;
      if (item.action == ACT_START) begin
         if (write_remaining_ff != '0 || read_remaining_ff != '0) begin
            rsp.request_status = 1'b1;
         end else begin
            slave_addr_in      = item.target_address;
            write_remaining_in = COUNT_WIDTH'(item.write_count);
            read_remaining_in  = COUNT_WIDTH'(item.read_count);
            rsp.start_ctl      = CTL_SET;
         end
      end else begin
         rsp.continue_bus = 1'b1;
         unique case (item.bus_status) inside
            BUS_START, BUS_RSTART: begin
               rsp.data_load = 1'b1;
               rsp.data_out  = {slave_addr_ff, write_remaining_ff == '0};
               rsp.start_ctl = CTL_CLR;
            end
            BUS_SLAW_ACK, BUS_WR_ACK: begin
               if (write_remaining_ff != '0) begin
                  rsp.data_load      = 1'b1;
                  rsp.data_out       = item.write_byte;
                  rsp.write_consumed = 1'b1;
                  write_remaining_in = write_remaining_ff - COUNT_WIDTH'(1);
               end else if (read_remaining_ff != '0) begin
                  rsp.start_ctl = CTL_SET;
               end else begin
                  rsp.stop_set    = 1'b1;
                  rsp.done_res    = 1'b1;
                  rsp.done_status = DONE_OK;
               end
            end
            BUS_SLAW_NACK, BUS_SLAR_NACK, BUS_WR_NACK, BUS_ARB_LOST: begin
               write_remaining_in = '0;
               read_remaining_in  = '0;
               rsp.start_ctl      = CTL_CLR;
               rsp.ack_ctl        = CTL_CLR;
               rsp.done_res       = 1'b1;
               rsp.stop_set       = item.bus_status != BUS_ARB_LOST;
               if (item.bus_status == BUS_ARB_LOST) begin
                  rsp.done_status = DONE_ARB;
               end else if (item.bus_status == BUS_WR_NACK) begin
                  rsp.done_status = DONE_DATA;
               end else begin
                  rsp.done_status = DONE_ADDR;
               end
            end
            BUS_SLAR_ACK: begin
               if (read_remaining_ff > COUNT_WIDTH'(1)) begin
                  rsp.ack_ctl = CTL_SET;
               end
            end
            BUS_RD_ACK, BUS_RD_NACK: begin
               if (read_remaining_ff != '0) begin
                  rsp.read_valid    = 1'b1;
                  rsp.read_data     = item.read_byte;
                  read_remaining_in = read_dec;
                  if (read_dec <= COUNT_WIDTH'(1)) begin
                     rsp.ack_ctl = CTL_CLR;
                  end
               end
               if (read_remaining_ff <= COUNT_WIDTH'(1)) begin
                  rsp.stop_set    = 1'b1;
                  rsp.done_res    = 1'b1;
                  rsp.done_status = DONE_OK;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff      <= '0;
         write_remaining_ff <= '0;
         read_remaining_ff  <= '0;
      end else if (fire) begin
         slave_addr_ff      <= slave_addr_in;
         write_remaining_ff <= write_remaining_in;
         read_remaining_ff  <= read_remaining_in;
      end
   end

   `SEQ_ASSERT_NEXT(a_busy_keeps_state, clock, reset, fire && rsp.request_status, (write_remaining_ff == $past(write_remaining_ff)) && (read_remaining_ff == $past(read_remaining_ff)), "busy start changed counts")
   `SEQ_ASSERT_NEXT(a_done_clears_counts, clock, reset, fire && rsp.done_res, read_remaining_ff == '0, "read count left after completion")
   `SEQ_ASSERT_NEXT(a_write_count_steps, clock, reset, fire && rsp.write_consumed, write_remaining_ff == COUNT_WIDTH'($past(write_remaining_ff) - COUNT_WIDTH'(1)), "write count not decremented")
   `SEQ_ASSERT_NOW(a_stop_unless_arb, clock, reset, fire && rsp.done_res, rsp.stop_set == (rsp.done_status != DONE_ARB), "stop request wrong on completion")

endmodule

// ===== rtl/core/i2cms_out_stage.sv =====
`timescale 1ns / 1ps
module i2cms_out_stage
   import i2cms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type load_item,
   output logic         slot_free,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign slot_free = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule

// ===== rtl/core/i2c_master_sequencer.sv =====
`timescale 1ns / 1ps
// I2C master write-then-read sequencer.
// req channel: tuser = action (0 start request, 1 bus status event); tdata carries the
//   target address, both counts, the bus status and the write/read bytes.
// rsp channel: one item for every req item, in order, holding the engine controls
//   (data load, start/ack/stop control, interrupt clear), a received byte and the
//   completion notice. A start request answers busy while any count is nonzero.
// Path: a req item taken into the input register is decoded and its result is written
//   to the result register once that register is free; rsp takes it from there.
// Throughput: one item per cycle while the rsp side keeps taking results; the decode
//   between the input register and the result register is a single pass over the address and two count registers.
// Reset clears the address and counts and empties both registers.
// A stalled rsp side holds the pending result; one more req item is held in the
//   input register and req_tready then drops until the result is taken.
module i2c_master_sequencer
   import i2cms_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // target_address[6:0], write_count[22:7], read_count[38:23], bus_status[42:39],
   // write_byte[50:43], read_byte[58:51], zero fill
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   // action
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // request_status[0], data_load[1], data_out[9:2], start_ctl[11:10], ack_ctl[13:12],
   // stop_set[14], continue_bus[15], write_consumed[16], read_valid[17],
   // read_data[25:18], done_res[26], done_status[28:27], zero fill
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   req_item_type in_item;
   req_item_type held_item;
   logic         held_valid;
   logic         held_take;
   logic         slot_free;
   logic         rsp_load;
   rsp_item_type rsp_item;
   rsp_item_type out_item;

   always_comb begin
      in_item.action         = action_type'(req_tuser);
      in_item.target_address = req_tdata[6:0];
      in_item.write_count    = req_tdata[22:7];
      in_item.read_count     = req_tdata[38:23];
      in_item.bus_status     = req_tdata[42:39];
      in_item.write_byte     = req_tdata[50:43];
      in_item.read_byte      = req_tdata[58:51];
   end

   assign rsp_tdata = {3'b000, out_item.done_status, out_item.done_res, out_item.read_data,
                       out_item.read_valid, out_item.write_consumed, out_item.continue_bus,
                       out_item.stop_set, out_item.ack_ctl, out_item.start_ctl,
                       out_item.data_out, out_item.data_load, out_item.request_status};

   i2cms_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .held_valid (held_valid),
      .held_item  (held_item),
      .held_take  (held_take)
   );

   i2cms_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (held_valid),
      .item       (held_item),
      .item_take  (held_take),
      .slot_free  (slot_free),
      .rsp_load   (rsp_load),
      .rsp_item   (rsp_item)
   );

   i2cms_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_item (rsp_item),
      .slot_free (slot_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

endmodule

// ===== dv/i2c_master_sequencer_tb.sv =====
`timescale 1ns / 1ps
module i2c_master_sequencer_tb;
   import i2cms_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RANDOM_ITEMS   = 1650;
   localparam int CALM_ITEMS     = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int STEP_CAP       = 24;
   localparam int REQ_ITEM_BITS  = $bits(req_item_type);

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic                       req_tuser  = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;

   // predictor state
   logic [6:0]             tgt_addr = '0;
   logic [COUNT_WIDTH-1:0] wr_left  = '0;
   logic [COUNT_WIDTH-1:0] rd_left  = '0;

   rsp_item_type pending_controls[$];

   bit idle_on       = 1'b1;
   int items_sent    = 0;
   int results_seen  = 0;
   int transfers_run = 0;
   int done_seen     = 0;
   int mismatches    = 0;
   int quiet_cycles  = 0;
   int stall_left    = 0;

   i2c_master_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic void end_transfer(inout rsp_item_type r, input done_type st,
                                        input logic stop, input logic abort);
      if (abort) begin
         wr_left     = '0;
         rd_left     = '0;
         r.start_ctl = CTL_CLR;
         r.ack_ctl   = CTL_CLR;
      end
      r.stop_set     = stop;
      r.continue_bus = 1'b1;
      r.done_res     = 1'b1;
      r.done_status  = st;
   endfunction

   function automatic rsp_item_type predict_bus_controls(input req_item_type it);
      rsp_item_type r;
      r = '0;
      if (it.action == ACT_START) begin
         if (wr_left != 0 || rd_left != 0) begin
            r.request_status = 1'b1;
         end else begin
            tgt_addr    = it.target_address;
            wr_left     = it.write_count;
            rd_left     = it.read_count;
            r.start_ctl = CTL_SET;
         end
      end else begin
         r.continue_bus = 1'b1;
         case (it.bus_status)
            BUS_START, BUS_RSTART: begin
               r.data_load = 1'b1;
               r.data_out  = {tgt_addr, wr_left == 0};
               r.start_ctl = CTL_CLR;
            end
            BUS_SLAW_ACK, BUS_WR_ACK: begin
               if (wr_left != 0) begin
                  r.data_load      = 1'b1;
                  r.data_out       = it.write_byte;
                  r.write_consumed = 1'b1;
                  wr_left          = wr_left - 1'b1;
               end else if (rd_left != 0) begin
                  r.start_ctl = CTL_SET;
               end else begin
                  end_transfer(r, DONE_OK, 1'b1, 1'b0);
               end
            end
            BUS_SLAW_NACK, BUS_SLAR_NACK: end_transfer(r, DONE_ADDR, 1'b1, 1'b1);
            BUS_WR_NACK:                  end_transfer(r, DONE_DATA, 1'b1, 1'b1);
            BUS_ARB_LOST:                 end_transfer(r, DONE_ARB, 1'b0, 1'b1);
            BUS_SLAR_ACK: begin
               if (rd_left > 1) r.ack_ctl = CTL_SET;
            end
            BUS_RD_ACK, BUS_RD_NACK: begin
               if (rd_left != 0) begin
                  r.read_valid = 1'b1;
                  r.read_data  = it.read_byte;
                  rd_left      = rd_left - 1'b1;
                  if (rd_left <= 1) r.ack_ctl = CTL_CLR;
               end
               if (rd_left == 0) end_transfer(r, DONE_OK, 1'b1, 1'b0);
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- driving
   function automatic req_item_type rand_item();
      return req_item_type'(REQ_ITEM_BITS'({$urandom, $urandom}));
   endfunction

   task automatic send_item(input req_item_type it);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {5'd0, it.read_byte, it.write_byte, it.bus_status, it.read_count,
                     it.write_count, it.target_address};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_controls.push_back(predict_bus_controls(it));
      items_sent++;
      if (items_sent >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
   endtask

   task automatic send_start(input logic [6:0] addr, input logic [15:0] wcount,
                             input logic [15:0] rcount);
      req_item_type it;
      it                = rand_item();
      it.action         = ACT_START;
      it.target_address = addr;
      it.write_count    = wcount;
      it.read_count     = rcount;
      send_item(it);
   endtask

   task automatic send_event(input logic [3:0] st, input logic [7:0] wbyte,
                             input logic [7:0] rbyte);
      req_item_type it;
      it            = rand_item();
      it.action     = ACT_EVENT;
      it.bus_status = st;
      it.write_byte = wbyte;
      it.read_byte  = rbyte;
      send_item(it);
   endtask

   task automatic send_status(input logic [3:0] st);
      send_event(st, 8'($urandom), 8'($urandom));
   endtask

   // mostly the expected status, now and then a fault or a stray code
   function automatic logic [3:0] pick_status(input logic [3:0] normal);
      int r;
      r = $urandom_range(0, 39);
      case (r)
         0:       return BUS_ARB_LOST;
         1:       return (normal == BUS_SLAR_ACK) ? BUS_SLAR_NACK : BUS_SLAW_NACK;
         2:       return BUS_WR_NACK;
         3:       return 4'($urandom_range(BUS_OTHER, 15));
         4:       return 4'($urandom_range(0, 15));
         default: return normal;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      string        bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.request_status = rsp_tdata[0];
         got.data_load      = rsp_tdata[1];
         got.data_out       = rsp_tdata[9:2];
         got.start_ctl      = ctl_type'(rsp_tdata[11:10]);
         got.ack_ctl        = ctl_type'(rsp_tdata[13:12]);
         got.stop_set       = rsp_tdata[14];
         got.continue_bus   = rsp_tdata[15];
         got.write_consumed = rsp_tdata[16];
         got.read_valid     = rsp_tdata[17];
         got.read_data      = rsp_tdata[25:18];
         got.done_res       = rsp_tdata[26];
         got.done_status    = done_type'(rsp_tdata[28:27]);
         results_seen++;
         if (got.done_res === 1'b1) done_seen++;
         if (pending_controls.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing expected: %h", $realtime, rsp_tdata);
         end else begin
            want = pending_controls.pop_front();
            bad  = "";
            if (got.request_status !== want.request_status) bad = {bad, " request_status"};
            if (got.data_load      !== want.data_load)      bad = {bad, " data_load"};
            if (got.data_out       !== want.data_out)       bad = {bad, " data_out"};
            if (got.start_ctl      !== want.start_ctl)      bad = {bad, " start_ctl"};
            if (got.ack_ctl        !== want.ack_ctl)        bad = {bad, " ack_ctl"};
            if (got.stop_set       !== want.stop_set)       bad = {bad, " stop_set"};
            if (got.continue_bus   !== want.continue_bus)   bad = {bad, " continue_bus"};
            if (got.write_consumed !== want.write_consumed) bad = {bad, " write_consumed"};
            if (got.read_valid     !== want.read_valid)     bad = {bad, " read_valid"};
            if (got.read_data      !== want.read_data)      bad = {bad, " read_data"};
            if (got.done_res       !== want.done_res)       bad = {bad, " done_res"};
            if (got.done_status    !== want.done_status)    bad = {bad, " done_status"};
            if (bad != "") begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result %0d mismatch on%s: expected %p, got %p",
                           $realtime, results_seen, bad, want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 15);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_controls.size());
      $display("i2c_master_sequencer_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- tests
   task automatic test_idle_events();
      send_status(BUS_WR_ACK);
      send_status(BUS_RD_ACK);
      send_status(BUS_OTHER);
      send_status(4'd15);
      send_status(BUS_START);
   endtask

   task automatic test_empty_transfer();
      send_start(7'h7f, 16'd0, 16'd0);
      send_status(BUS_START);
   endtask

   task automatic test_write_then_read();
      send_start(7'h55, 16'd2, 16'd2);
      send_status(BUS_START);
      send_event(BUS_SLAW_ACK, 8'h00, 8'h00);
      send_event(BUS_WR_ACK, 8'hff, 8'hff);
      send_start(7'h7f, 16'hffff, 16'hffff);
      send_status(BUS_WR_ACK);
      send_status(BUS_RSTART);
      send_status(BUS_SLAR_ACK);
      send_event(BUS_RD_ACK, 8'h00, 8'hff);
      send_event(BUS_RD_NACK, 8'hff, 8'h00);
   endtask

   task automatic test_failures();
      send_start(7'h00, 16'hffff, 16'hffff);
      send_status(BUS_SLAW_NACK);
      send_start(7'h7f, 16'hffff, 16'd1);
      send_status(BUS_WR_NACK);
      send_start(7'h01, 16'd0, 16'hffff);
      send_status(BUS_ARB_LOST);
   endtask

   task automatic run_transfer(input int max_count);
      int steps;
      steps = 0;
      transfers_run++;
      send_start(7'($urandom), 16'($urandom_range(0, max_count)),
                 16'($urandom_range(0, max_count)));
      send_status(pick_status(BUS_START));
      if ($urandom_range(0, 5) == 0) send_start(7'($urandom), 16'($urandom), 16'($urandom));
      if (wr_left != 0) begin
         send_status(pick_status(BUS_SLAW_ACK));
         while (wr_left != 0 && steps < STEP_CAP) begin
            send_status(pick_status(BUS_WR_ACK));
            steps++;
         end
         send_status(pick_status(BUS_WR_ACK));
         if (rd_left != 0) send_status(pick_status(BUS_RSTART));
      end
      if (rd_left != 0) begin
         send_status(pick_status(BUS_SLAR_ACK));
         while (rd_left > 1 && steps < 2 * STEP_CAP) begin
            send_status(pick_status(BUS_RD_ACK));
            steps++;
         end
         send_status(pick_status(BUS_RD_NACK));
      end
      if (wr_left != 0 || rd_left != 0) send_status(BUS_ARB_LOST);
   endtask

   // full-range counts, torn down after a few events
   task automatic run_aborted_transfer();
      transfers_run++;
      send_start(7'($urandom), 16'($urandom), 16'($urandom));
      repeat ($urandom_range(1, 3)) send_status(4'($urandom_range(0, 15)));
      send_status($urandom_range(0, 1) ? BUS_ARB_LOST : BUS_SLAR_NACK);
   endtask

   task automatic test_random_transfers();
      int pick;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick < 14)
            run_transfer(5);
         else if (pick < 16)
            run_transfer(40);
         else if (pick < 18)
            run_aborted_transfer();
         else
            repeat ($urandom_range(1, 4)) send_item(rand_item());
      end
      if (wr_left != 0 || rd_left != 0) send_status(BUS_ARB_LOST);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_events();
      test_empty_transfer();
      test_write_then_read();
      test_failures();
      test_random_transfers();
      req_tvalid <= 1'b0;
      while (pending_controls.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d items sent over %0d random transfers plus directed cases", items_sent,
               transfers_run);
      $display("%0d results checked, %0d completions, %0d mismatches", results_seen,
               done_seen, mismatches);
      if (mismatches == 0 && pending_controls.size() == 0) begin
         $display("i2c_master_sequencer_tb: PASS");
      end else begin
         $display("i2c_master_sequencer_tb: FAIL");
      end
      $finish;
   end

endmodule
